>>> rtl/chtab_pkg.sv
package chtab_pkg;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_HRD   = 7'b0001000,
    ST_HUSE  = 7'b0010000,
    ST_NUSE  = 7'b0100000,
    ST_DEL2  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RSVD      = 2'd3
  } status_e;

  // register select, paddr bit 2
  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_BUCKETS = 1'b1;

  localparam logic [10:0] BUCKETS_RESET = 11'd1024;

endpackage

>>> rtl/chtab_div.sv
module chtab_div #(
  parameter int DW = 32,
  parameter int NW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] rem_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q, dvd_d;
  logic [NW-1:0]   dvs_q, dvs_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [NW:0]     trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, dvd_q[DW-1]};
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = NW'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[NW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNTW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/chained_hash_table.sv
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------------------
// command   | in        | start / busy       | mode_i, key_i, record_i
// result    | out       | done_o (1 cycle)   | status_o, found_record_o, used_buckets_o,
//           |           |                    | collision_total_o
// config    | in        | apb psel/penable   | table_enabled @0x0, bucket_count @0x4
//
// an operation runs in the serial modulo unit (ST_DIV), then reads the bucket head
// (ST_HRD, ST_HUSE), then walks the chain in ST_NUSE with one memory read per node, plus
// ST_DEL2 for a delete; a disabled table, an unused mode or an insert into a full table
// answers straight from ST_IDLE.
// after reset and after every write of table_enabled the bucket head memory is cleared
// in ST_CLEAR with busy high; results come out one cycle wide and cannot be stalled.
module chained_hash_table #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_NODES  = 1024,
  parameter int KEY_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] record_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] found_record_o,
  output logic [31:0] used_buckets_o,
  output logic [31:0] collision_total_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import chtab_pkg::*;

  localparam int KB  = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int NW  = $clog2(MAX_BUCKETS + 1);
  localparam int CW  = (NW > 11) ? NW : 11;
  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NIW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int FW  = $clog2(POOL_NODES + 1);

  state_e         state_q, state_d;
  logic           en_q;
  logic [10:0]    bcnt_q;
  logic [1:0]     mode_q;
  logic [KB-1:0]  key_q;
  logic [31:0]    rec_q;
  logic [BW-1:0]  bkt_q;
  logic [BW-1:0]  clr_q;
  logic [NIW-1:0] cur_q, prev_q;
  logic           have_prev_q;
  logic [NIW-1:0] free_head_q;
  logic           free_valid_q;
  logic [FW-1:0]  fresh_q;
  logic [31:0]    empty_cnt_q, chain_cnt_q;
  logic           done_q;
  logic [1:0]     status_q;
  logic [31:0]    found_q;

  // memories: bucket heads and node pool
  logic [NIW:0]   head_mem [MAX_BUCKETS];
  logic [KB-1:0]  key_mem  [POOL_NODES];
  logic [31:0]    rec_mem  [POOL_NODES];
  logic [NIW:0]   link_mem [POOL_NODES];

  logic [NIW:0]   h_rd_q;
  logic [KB-1:0]  n_key_q;
  logic [31:0]    n_rec_q;
  logic [NIW:0]   n_link_q;

  logic           h_we;
  logic [BW-1:0]  h_waddr;
  logic [NIW:0]   h_wdata;
  logic           n_we_all, n_we_link;
  logic [NIW-1:0] n_waddr, n_raddr;
  logic [NIW:0]   n_wlink;

  logic           cfg_wr, accept, full;
  logic           div_start, div_done;
  logic [CW-1:0]  bc_ext;
  logic [NW-1:0]  divisor;
  logic [NW-1:0]  div_rem;
  logic [NIW-1:0] new_node;
  logic           key_hit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BUCKETS) ? {21'b0, bcnt_q} : {31'b0, en_q};
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign full   = !free_valid_q && (fresh_q == FW'(POOL_NODES));
  assign new_node = free_valid_q ? free_head_q : fresh_q[NIW-1:0];
  assign key_hit  = (n_key_q == key_q);

  // zero acts as one, too large clamps to the top
  always_comb begin
    bc_ext = CW'(bcnt_q);
    if (bc_ext == '0) begin
      divisor = NW'(1);
    end else if (bc_ext > CW'(MAX_BUCKETS)) begin
      divisor = NW'(MAX_BUCKETS);
    end else begin
      divisor = NW'(bc_ext);
    end
  end

  assign div_start = accept && en_q && (mode_i != MODE_NONE)
                     && !((mode_i == MODE_INSERT) && full);

  chtab_div #(
    .DW(KB),
    .NW(NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_i[KB-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // node read address follows the walk, or the free-list head in ST_HRD
  always_comb begin
    case (state_q)
      ST_HRD:  n_raddr = free_head_q;
      ST_HUSE: n_raddr = h_rd_q[NIW-1:0];
      ST_NUSE: n_raddr = n_link_q[NIW-1:0];
      default: n_raddr = cur_q;
    endcase
  end

  // memory write ports
  always_comb begin
    h_we      = 1'b0;
    h_waddr   = bkt_q;
    h_wdata   = h_rd_q;
    n_we_all  = 1'b0;
    n_we_link = 1'b0;
    n_waddr   = cur_q;
    n_wlink   = n_link_q;
    unique case (state_q)
      ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
      end
      ST_HUSE: begin
        if (mode_q == MODE_INSERT) begin
          h_we      = 1'b1;
          h_wdata   = {1'b1, new_node};
          n_we_all  = 1'b1;
          n_we_link = 1'b1;
          n_waddr   = new_node;
          n_wlink   = h_rd_q;
        end
      end
      ST_NUSE: begin
        if (key_hit && (mode_q == MODE_DELETE)) begin
          if (have_prev_q) begin
            n_we_link = 1'b1;
            n_waddr   = prev_q;
            n_wlink   = n_link_q;
          end else begin
            h_we    = 1'b1;
            h_wdata = n_link_q;
          end
        end
      end
      ST_DEL2: begin
        n_we_link = 1'b1;
        n_waddr   = cur_q;
        n_wlink   = {free_valid_q, free_head_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      head_mem[h_waddr] <= h_wdata;
    end
    h_rd_q <= head_mem[bkt_q];
  end

  always_ff @(posedge clk_i) begin
    if (n_we_all) begin
      key_mem[n_waddr] <= key_q;
      rec_mem[n_waddr] <= rec_q;
    end
    if (n_we_link) begin
      link_mem[n_waddr] <= n_wlink;
    end
    n_key_q  <= key_mem[n_raddr];
    n_rec_q  <= rec_mem[n_raddr];
    n_link_q <= link_mem[n_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (div_start) state_d = ST_DIV;
      ST_CLEAR: if (clr_q == BW'(MAX_BUCKETS - 1)) state_d = ST_IDLE;
      ST_DIV:   if (div_done) state_d = ST_HRD;
      ST_HRD:   state_d = ST_HUSE;
      ST_HUSE: begin
        if (mode_q == MODE_INSERT || !h_rd_q[NIW]) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_NUSE;
        end
      end
      ST_NUSE: begin
        if (key_hit) begin
          state_d = (mode_q == MODE_DELETE) ? ST_DEL2 : ST_IDLE;
        end else if (!n_link_q[NIW]) begin
          state_d = ST_IDLE;
        end
      end
      ST_DEL2:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_wr && (paddr[2] == REG_ENABLE)) begin
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      en_q         <= 1'b0;
      bcnt_q       <= BUCKETS_RESET;
      clr_q        <= '0;
      free_valid_q <= 1'b0;
      free_head_q  <= '0;
      fresh_q      <= '0;
      empty_cnt_q  <= '0;
      chain_cnt_q  <= '0;
      done_q       <= 1'b0;
      status_q     <= STAT_NOT_FOUND;
      found_q      <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && !div_start) begin
            done_q   <= 1'b1;
            status_q <= (en_q && mode_i == MODE_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
            found_q  <= '0;
          end
        end
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_HUSE: begin
          if (mode_q == MODE_INSERT) begin
            if (free_valid_q) begin
              free_head_q  <= n_link_q[NIW-1:0];
              free_valid_q <= n_link_q[NIW];
            end else begin
              fresh_q <= fresh_q + 1'b1;
            end
            if (h_rd_q[NIW]) begin
              if (chain_cnt_q != '1) chain_cnt_q <= chain_cnt_q + 1'b1;
            end else begin
              if (empty_cnt_q != '1) empty_cnt_q <= empty_cnt_q + 1'b1;
            end
            done_q   <= 1'b1;
            status_q <= STAT_OK;
            found_q  <= '0;
          end else if (!h_rd_q[NIW]) begin
            done_q   <= 1'b1;
            status_q <= STAT_NOT_FOUND;
            found_q  <= '0;
          end
        end
        ST_NUSE: begin
          if (key_hit) begin
            if (mode_q == MODE_FIND) begin
              done_q   <= 1'b1;
              status_q <= STAT_OK;
              found_q  <= n_rec_q;
            end
          end else if (!n_link_q[NIW]) begin
            done_q   <= 1'b1;
            status_q <= STAT_NOT_FOUND;
            found_q  <= '0;
          end
        end
        ST_DEL2: begin
          free_head_q  <= cur_q;
          free_valid_q <= 1'b1;
          done_q       <= 1'b1;
          status_q     <= STAT_OK;
          found_q      <= '0;
        end
        default: begin
        end
      endcase
      if (cfg_wr) begin
        if (paddr[2] == REG_ENABLE) begin
          en_q         <= pwdata[0];
          clr_q        <= '0;
          free_valid_q <= 1'b0;
          fresh_q      <= '0;
          empty_cnt_q  <= '0;
          chain_cnt_q  <= '0;
        end else begin
          bcnt_q <= pwdata[10:0];
        end
      end
    end
  end

  // walk position and captured command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= key_i[KB-1:0];
      rec_q  <= record_i;
    end
    if (div_done) begin
      bkt_q <= div_rem[BW-1:0];
    end
    if (state_q == ST_HUSE) begin
      cur_q       <= h_rd_q[NIW-1:0];
      have_prev_q <= 1'b0;
    end else if (state_q == ST_NUSE && !key_hit) begin
      prev_q      <= cur_q;
      cur_q       <= n_link_q[NIW-1:0];
      have_prev_q <= 1'b1;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign found_record_o    = found_q;
  assign used_buckets_o    = empty_cnt_q;
  assign collision_total_o = chain_cnt_q;

  a_state_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= FW'(POOL_NODES)) else $error("fresh node count past pool size");

  a_full_real : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> full)
    else $error("table full reported with free nodes");

  a_div_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !cfg_wr) |=> (state_q == ST_DIV || state_q == ST_HRD))
    else $error("bad exit from modulo state");

endmodule

>>> tb/sv/chained_hash_table_tb.sv
module chained_hash_table_tb;
  import chtab_pkg::*;

  localparam logic [2:0] ADDR_ENABLE  = {REG_ENABLE, 2'b00};
  localparam logic [2:0] ADDR_BUCKETS = {REG_BUCKETS, 2'b00};
  localparam int         NODES        = 1024;
  localparam int         HEADS        = 1024;

  typedef struct {
    status_e     status;
    logic [31:0] found;
    logic [31:0] used;
    logic [31:0] coll;
  } lookup_result_t;

  typedef struct {
    bit          is_reg;
    logic [2:0]  addr;
    logic [31:0] data;
    mode_e       mode;
    logic [31:0] key;
    logic [31:0] rec;
    bit          typed;
    status_e     exp_status;
    logic [31:0] exp_found;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode_i = MODE_NONE;
  logic [31:0] key_i = '0;
  logic [31:0] record_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] found_record_o;
  logic [31:0] used_buckets_o;
  logic [31:0] collision_total_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chained_hash_table i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .key_i, .record_i, .done_o, .status_o,
    .found_record_o, .used_buckets_o, .collision_total_o, .psel, .penable, .pwrite,
    .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the table
  bit [9:0]    chain_head [HEADS];
  bit          chain_live [HEADS];
  logic [31:0] node_key   [NODES];
  logic [31:0] node_rec   [NODES];
  bit [9:0]    node_next  [NODES];
  bit          next_live  [NODES];
  bit [9:0]    free_node;
  bit          free_live;
  logic [31:0] empty_inserts, chained_inserts;
  bit          tbl_on;
  logic [10:0] tbl_buckets;

  lookup_result_t pending_results[$];
  logic [31:0]    recent_keys[$];
  int             n_errors = 0;
  int             n_results = 0;
  int             n_full = 0;
  int             n_hits = 0;
  bit             steady = 1'b0;

  function automatic void clear_table();
    for (int i = 0; i < HEADS; i++) chain_live[i] = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      node_next[i] = 10'(i + 1);
      next_live[i] = (i + 1) < NODES;
    end
    free_node       = '0;
    free_live       = 1'b1;
    empty_inserts   = '0;
    chained_inserts = '0;
  endfunction

  function automatic int bucket_of(logic [31:0] key);
    int n;
    n = tbl_buckets;
    if (n == 0) n = 1;
    if (n > HEADS) n = HEADS;
    return int'(key % 32'(n));
  endfunction

  function automatic lookup_result_t apply_op(mode_e mode, logic [31:0] key, logic [31:0] rec);
    lookup_result_t r;
    int b, cur, prev, steps;
    bit have, have_prev;
    r.status = STAT_NOT_FOUND;
    r.found  = '0;
    if (tbl_on && mode == MODE_INSERT) begin
      if (!free_live) begin
        r.status = STAT_FULL;
      end else begin
        b = bucket_of(key);
        cur = free_node;
        free_node = node_next[cur];
        free_live = next_live[cur];
        node_key[cur] = key;
        node_rec[cur] = rec;
        node_next[cur] = chain_head[b];
        next_live[cur] = chain_live[b];
        if (chain_live[b]) begin
          if (chained_inserts != '1) chained_inserts++;
        end else if (empty_inserts != '1) begin
          empty_inserts++;
        end
        chain_head[b] = 10'(cur);
        chain_live[b] = 1'b1;
        r.status = STAT_OK;
      end
    end else if (tbl_on && (mode == MODE_DELETE || mode == MODE_FIND)) begin
      b = bucket_of(key);
      cur = chain_head[b];
      have = chain_live[b];
      prev = 0;
      have_prev = 1'b0;
      steps = 0;
      while (have && node_key[cur] != key && steps < NODES) begin
        prev = cur;
        have_prev = 1'b1;
        have = next_live[cur];
        cur = node_next[cur];
        steps++;
      end
      if (have && node_key[cur] == key) begin
        r.status = STAT_OK;
        if (mode == MODE_FIND) begin
          r.found = node_rec[cur];
        end else begin
          if (have_prev) begin
            node_next[prev] = node_next[cur];
            next_live[prev] = next_live[cur];
          end else begin
            chain_head[b] = node_next[cur];
            chain_live[b] = next_live[cur];
          end
          node_next[cur] = free_node;
          next_live[cur] = free_live;
          free_node = 10'(cur);
          free_live = 1'b1;
        end
      end
    end
    r.used = empty_inserts;
    r.coll = chained_inserts;
    return r;
  endfunction

  // one command transaction; typed expectation overrides status and record
  task automatic send_op(mode_e mode, logic [31:0] key, logic [31:0] rec,
                         bit typed = 1'b0, status_e ts = STAT_OK, logic [31:0] tf = '0);
    lookup_result_t r;
    if (!steady && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    start    <= 1'b1;
    mode_i   <= mode;
    key_i    <= key;
    record_i <= rec;
    do @(posedge clk_i); while (busy);
    r = apply_op(mode, key, rec);
    if (typed) begin
      r.status = ts;
      r.found  = tf;
    end
    if (r.status == STAT_FULL) n_full++;
    if (r.status == STAT_OK && mode != MODE_INSERT) n_hits++;
    if (mode == MODE_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 48) void'(recent_keys.pop_front());
    end
    pending_results.push_back(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ENABLE) begin
      tbl_on = data[0];
      clear_table();
    end else begin
      tbl_buckets = data[10:0];
    end
  endtask

  function automatic logic [31:0] pick_key();
    if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    return $urandom;
  endfunction

  task automatic random_op();
    int r;
    mode_e m;
    r = $urandom_range(0, 99);
    if (r < 40) m = MODE_INSERT;
    else if (r < 65) m = MODE_DELETE;
    else if (r < 95) m = MODE_FIND;
    else m = MODE_NONE;
    send_op(m, pick_key(), $urandom);
  endtask

  always @(posedge clk_i) begin
    lookup_result_t e;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (status_o != e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          n_errors++;
        end
        if (found_record_o != e.found) begin
          $error("found_record: expected %h, got %h", e.found, found_record_o);
          n_errors++;
        end
        if (used_buckets_o != e.used) begin
          $error("used_buckets: expected %0d, got %0d", e.used, used_buckets_o);
          n_errors++;
        end
        if (collision_total_o != e.coll) begin
          $error("collision_total: expected %0d, got %0d", e.coll, collision_total_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d transactions outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    op_row_t rows[$];
    int      phase_buckets[9];
    int      phase_enable[9];
    int      phase_items[9];
    tbl_on = 1'b0;
    tbl_buckets = BUCKETS_RESET;
    clear_table();
    rows = '{
      '{0, 0, 0, MODE_INSERT, 32'h0, 32'h1, 1, STAT_NOT_FOUND, 32'h0},
      '{0, 0, 0, MODE_DELETE, 32'h0, 32'h0, 1, STAT_NOT_FOUND, 32'h0},
      '{0, 0, 0, MODE_FIND, 32'hFFFFFFFF, 32'h0, 1, STAT_NOT_FOUND, 32'h0},
      '{0, 0, 0, MODE_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, STAT_NOT_FOUND, 32'h0},
      '{1, ADDR_ENABLE, 32'h1, MODE_NONE, 0, 0, 0, STAT_OK, 0},
      '{1, ADDR_BUCKETS, 32'h0, MODE_NONE, 0, 0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, STAT_OK, 32'h0},
      '{0, 0, 0, MODE_INSERT, 32'h0, 32'h0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_INSERT, 32'h0, 32'h5, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'h0, 32'h0, 1, STAT_OK, 32'h5},
      '{0, 0, 0, MODE_DELETE, 32'h0, 32'h0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'h0, 32'h0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'hFFFFFFFF, 32'h0, 1, STAT_OK, 32'hFFFFFFFF},
      '{0, 0, 0, MODE_DELETE, 32'h123, 32'h0, 1, STAT_NOT_FOUND, 32'h0},
      '{0, 0, 0, MODE_NONE, 32'h0, 32'h0, 1, STAT_NOT_FOUND, 32'h0},
      '{1, ADDR_BUCKETS, 32'h7FF, MODE_NONE, 0, 0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'hFFFFFFFF, 32'h0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_INSERT, 32'h400, 32'hA5A5A5A5, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'h400, 32'h0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_DELETE, 32'hFFFFFFFF, 32'h0, 0, STAT_OK, 0},
      '{1, ADDR_ENABLE, 32'h1, MODE_NONE, 0, 0, 0, STAT_OK, 0},
      '{0, 0, 0, MODE_FIND, 32'h400, 32'h0, 1, STAT_NOT_FOUND, 32'h0}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      if (rows[i].is_reg) write_reg(rows[i].addr, rows[i].data);
      else send_op(rows[i].mode, rows[i].key, rows[i].rec, rows[i].typed,
                   rows[i].exp_status, rows[i].exp_found);
    end

    // fill the whole node pool, then run past it
    write_reg(ADDR_ENABLE, 32'h1);
    write_reg(ADDR_BUCKETS, 32'd1024);
    for (int i = 0; i < NODES + 6; i++) send_op(MODE_INSERT, $urandom, $urandom);
    for (int i = 0; i < 40; i++) random_op();

    phase_enable  = '{1, 1, 1, 0, 1, 1, 1, 1, 1};
    phase_buckets = '{1, 1024, 3, 5, 0, 2047, 37, 2, $urandom_range(1, 1024)};
    phase_items   = '{60, 110, 80, 30, 40, 80, 80, 40, 80};
    for (int p = 0; p < 9; p++) begin
      if (phase_enable[p] != 32'(tbl_on) || p == 0) write_reg(ADDR_ENABLE, phase_enable[p]);
      write_reg(ADDR_BUCKETS, phase_buckets[p]);
      if (p == 8) steady = 1'b1;
      for (int i = 0; i < phase_items[p]; i++) random_op();
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d results: disabled table, bucket counts 0 to 2047, pool exhaustion",
             n_results);
    $display("%0d table-full answers, %0d delete/find hits", n_full, n_hits);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
